// ----- hw/rtl/mpq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the sorted priority queue.
// Used by the cell, the core and the port checker; depends on nothing.
package mpq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned DATA_W        = 32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_PEEK   = 2'd1,
    MODE_POP    = 2'd2,
    MODE_LIST   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_DUP   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [DATA_W-1:0]   key;
    logic [DATA_W-1:0]   value;
  } cell_cmd_t;

endpackage

// ----- hw/rtl/mpq_cell.sv -----
`timescale 1ns / 1ps
// One slot of the sorted chain: holds a key and a value, compares against
// the broadcast key and trades contents with its neighbors. Uses mpq_pkg.
module mpq_cell (
  input  logic                      clk,
  input  mpq_pkg::cell_cmd_t        cmd,
  input  logic                      occ,
  input  logic                      tail,
  input  logic                      left_lt,
  input  logic [mpq_pkg::DATA_W-1:0] left_key,
  input  logic [mpq_pkg::DATA_W-1:0] left_value,
  input  logic [mpq_pkg::DATA_W-1:0] right_key,
  input  logic [mpq_pkg::DATA_W-1:0] right_value,
  input  logic [mpq_pkg::DATA_W-1:0] head_key,
  input  logic [mpq_pkg::DATA_W-1:0] head_value,
  output logic [mpq_pkg::DATA_W-1:0] key,
  output logic [mpq_pkg::DATA_W-1:0] value,
  output logic                      lt,
  output logic                      eq
);
  import mpq_pkg::*;

  logic [DATA_W-1:0] key_r, key_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;

  assign lt = occ && (key_r < cmd.key);
  assign eq = occ && (key_r == cmd.key);

  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    case (cmd.op)
      CELL_INSERT: begin
        // smaller keys stay; the first larger or free slot takes the new entry
        if (!lt) begin
          if (left_lt) begin
            key_nxt   = cmd.key;
            value_nxt = cmd.value;
          end else begin
            key_nxt   = left_key;
            value_nxt = left_value;
          end
        end
      end
      CELL_SHIFT: begin
        key_nxt   = right_key;
        value_nxt = right_value;
      end
      CELL_ROTATE: begin
        // the last held slot wraps around to the head
        if (tail) begin
          key_nxt   = head_key;
          value_nxt = head_value;
        end else begin
          key_nxt   = right_key;
          value_nxt = right_value;
        end
      end
      default: begin
        key_nxt   = key_r;
        value_nxt = value_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign key   = key_r;
  assign value = value_r;

endmodule

// ----- hw/rtl/min_priority_queue_core.sv -----
`timescale 1ns / 1ps
// Top level of the sorted priority queue: a chain of mpq_cell slots, the
// fill count, the list sequencer and the result register. Uses mpq_pkg.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  input   | in_valid in_stall in_mode in_value in_priority_req | in
//  result  | out_valid out_stall out_entry_value out_entry_priority out_status out_last | out
//
// Insert, peek and pop may follow back to back while the result is not stalled;
// the whole chain compares and shifts in parallel for each of them.
// List, once accepted, sends each held entry out from the head in turn, rotating
// the chain through its head; input is stalled until the last entry leaves.
// A stalled result holds the result register and stalls input.
// Reset clears the fill count, the sequencer and the result valid only.
module min_priority_queue_core #(
  parameter int unsigned DEPTH = mpq_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_mode,
  input  logic [mpq_pkg::DATA_W-1:0] in_value,
  input  logic [mpq_pkg::DATA_W-1:0] in_priority_req,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mpq_pkg::DATA_W-1:0] out_entry_value,
  output logic [mpq_pkg::DATA_W-1:0] out_entry_priority,
  output logic [1:0]                 out_status,
  output logic                       out_last
);
  import mpq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LIST = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_value_r, out_value_nxt;
  logic [DATA_W-1:0]  out_prio_r, out_prio_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic               out_last_r, out_last_nxt;

  cell_cmd_t                     cmd;
  logic [DEPTH-1:0][DATA_W-1:0]  cell_key;
  logic [DEPTH-1:0][DATA_W-1:0]  cell_value;
  logic [DEPTH-1:0]              cell_lt;
  logic [DEPTH-1:0]              cell_eq;

  logic out_free, in_acc, is_empty, is_full, is_dup, list_end;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_dup   = |cell_eq;
  assign list_end = (idx_r == count_r - CNT_W'(1));

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic              occ, tail, lft_lt;
      logic [DATA_W-1:0] lft_key, lft_value, rgt_key, rgt_value;

      assign occ  = CNT_W'(gi) < count_r;
      assign tail = CNT_W'(gi) == (count_r - CNT_W'(1));

      if (gi == 0) begin : g_first
        assign lft_lt    = 1'b1;
        assign lft_key   = cell_key[gi];
        assign lft_value = cell_value[gi];
      end else begin : g_inner
        assign lft_lt    = cell_lt[gi-1];
        assign lft_key   = cell_key[gi-1];
        assign lft_value = cell_value[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_end
        assign rgt_key   = cell_key[gi];
        assign rgt_value = cell_value[gi];
      end else begin : g_mid
        assign rgt_key   = cell_key[gi+1];
        assign rgt_value = cell_value[gi+1];
      end

      mpq_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occ         (occ),
        .tail        (tail),
        .left_lt     (lft_lt),
        .left_key    (lft_key),
        .left_value  (lft_value),
        .right_key   (rgt_key),
        .right_value (rgt_value),
        .head_key    (cell_key[0]),
        .head_value  (cell_value[0]),
        .key         (cell_key[gi]),
        .value       (cell_value[gi]),
        .lt          (cell_lt[gi]),
        .eq          (cell_eq[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    cmd.op         = CELL_HOLD;
    cmd.key        = in_priority_req;
    cmd.value      = in_value;
    out_value_nxt  = out_value_r;
    out_prio_nxt   = out_prio_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && out_stall;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_prio_nxt   = '0;
          out_status_nxt = STAT_OK;
          out_last_nxt   = 1'b1;
          case (mode_t'(in_mode))
            MODE_INSERT: begin
              if (is_dup) begin
                out_status_nxt = STAT_DUP;
              end else if (is_full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                cmd.op    = CELL_INSERT;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            MODE_PEEK, MODE_POP: begin
              if (is_empty) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                out_value_nxt = cell_value[0];
                out_prio_nxt  = cell_key[0];
                if (mode_t'(in_mode) == MODE_POP) begin
                  cmd.op    = CELL_SHIFT;
                  count_nxt = count_r - CNT_W'(1);
                end
              end
            end
            MODE_LIST: begin
              if (is_empty) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                // entries go out from the list sequencer
                out_valid_nxt = 1'b0;
                idx_nxt       = '0;
                state_nxt     = ST_LIST;
              end
            end
            default: begin
              out_status_nxt = STAT_OK;
            end
          endcase
        end
      end
      ST_LIST: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = cell_value[0];
          out_prio_nxt   = cell_key[0];
          out_status_nxt = STAT_OK;
          out_last_nxt   = list_end;
          cmd.op         = CELL_ROTATE;
          idx_nxt        = idx_r + CNT_W'(1);
          if (list_end) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_prio_r   <= out_prio_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_entry_value    = out_value_r;
  assign out_entry_priority = out_prio_r;
  assign out_status         = out_status_r;
  assign out_last           = out_last_r;

endmodule

// ----- hw/rtl/mpq_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the sorted priority queue core, bound to the top.
// Uses mpq_pkg for the status codes.
module mpq_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [mpq_pkg::DATA_W-1:0] out_entry_value,
  input logic [mpq_pkg::DATA_W-1:0] out_entry_priority,
  input logic [1:0]                 out_status,
  input logic                       out_last
);
  import mpq_pkg::*;

  // a stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entry_value)
      && $stable(out_entry_priority) && $stable(out_status) && $stable(out_last))
    else $error("stalled result changed");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> out_last)
    else $error("error status on a non-final result");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |->
      (out_entry_value == '0) && (out_entry_priority == '0))
    else $error("error status with nonzero entry");

  a_list_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input taken while a list is in progress");

endmodule

bind min_priority_queue_core mpq_checker u_mpq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_entry_value    (out_entry_value),
  .out_entry_priority (out_entry_priority),
  .out_status         (out_status),
  .out_last           (out_last)
);

// ----- verif/tb_min_priority_queue_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for min_priority_queue_core: a shadow sorted store
// predicts every result of insert, peek, pop and list under random flow control.
// Depends on mpq_pkg and min_priority_queue_core.
module tb_min_priority_queue_core;
  import mpq_pkg::*;

  localparam int QDEPTH      = DEPTH_DEFAULT;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 120;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] prio;
    status_t           status;
    logic              last;
  } entry_result_t;

  // Shadow of the sorted store plus the results still owed by the block.
  class pq_shadow;
    logic [DATA_W-1:0] keys [QDEPTH];
    logic [DATA_W-1:0] vals [QDEPTH];
    int                fill;
    int                peak_fill;
    entry_result_t     owed[$];
    int                errors;
    int                checked;
    int                n_mode [4];
    int                n_status [4];

    function void owe(logic [DATA_W-1:0] v, logic [DATA_W-1:0] p, status_t st, logic lst);
      entry_result_t e;
      e.value  = v;
      e.prio   = p;
      e.status = st;
      e.last   = lst;
      owed.push_back(e);
      n_status[int'(st)]++;
    endfunction

    function void note_command(mode_t m, logic [DATA_W-1:0] v, logic [DATA_W-1:0] p);
      int pos;
      n_mode[int'(m)]++;
      if (m == MODE_INSERT) begin
        pos = 0;
        while (pos < fill && keys[pos] < p) pos++;
        if (pos < fill && keys[pos] == p) begin
          owe('0, '0, STAT_DUP, 1'b1);
        end else if (fill >= QDEPTH) begin
          owe('0, '0, STAT_FULL, 1'b1);
        end else begin
          for (int i = fill; i > pos; i--) begin
            keys[i] = keys[i-1];
            vals[i] = vals[i-1];
          end
          keys[pos] = p;
          vals[pos] = v;
          fill++;
          if (fill > peak_fill) peak_fill = fill;
          owe('0, '0, STAT_OK, 1'b1);
        end
      end else if (fill == 0) begin
        owe('0, '0, STAT_EMPTY, 1'b1);
      end else if (m == MODE_LIST) begin
        for (int i = 0; i < fill; i++) owe(vals[i], keys[i], STAT_OK, i == fill - 1);
      end else begin
        owe(vals[0], keys[0], STAT_OK, 1'b1);
        if (m == MODE_POP) begin
          for (int i = 1; i < fill; i++) begin
            keys[i-1] = keys[i];
            vals[i-1] = vals[i];
          end
          fill--;
        end
      end
    endfunction

    function void check_entry(logic [DATA_W-1:0] v, logic [DATA_W-1:0] p, logic [1:0] st,
                              logic lst);
      entry_result_t e;
      if (owed.size() == 0) begin
        $error("unexpected result: value %h priority %h status %0d last %0b", v, p, st, lst);
        errors++;
        return;
      end
      e = owed.pop_front();
      checked++;
      if (v !== e.value) begin
        $error("entry_value: expected %h, got %h", e.value, v);
        errors++;
      end
      if (p !== e.prio) begin
        $error("entry_priority: expected %h, got %h", e.prio, p);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last: expected %0b, got %0b", e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_mode;
  logic [DATA_W-1:0] in_value;
  logic [DATA_W-1:0] in_priority_req;
  logic              out_valid;
  logic              out_stall;
  logic [DATA_W-1:0] out_entry_value;
  logic [DATA_W-1:0] out_entry_priority;
  logic [1:0]        out_status;
  logic              out_last;

  pq_shadow shadow;
  int       send_idle_pct;
  int       recv_idle_pct;
  bit       hold_req;
  int       quiet_cycles = 0;

  min_priority_queue_core #(.DEPTH(QDEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_value          (in_value),
    .in_priority_req   (in_priority_req),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_entry_value   (out_entry_value),
    .out_entry_priority(out_entry_priority),
    .out_status        (out_status),
    .out_last          (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, or one long hold when asked.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Sample both channels at the edge; watch for a hung pipeline.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        shadow.note_command(mode_t'(in_mode), in_value, in_priority_req);
      if (out_valid && !out_stall)
        shadow.check_entry(out_entry_value, out_entry_priority, out_status, out_last);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  task automatic drive_cmd(mode_t m, logic [DATA_W-1:0] v, logic [DATA_W-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= m;
    in_value        <= v;
    in_priority_req <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mix dense small keys, held keys and extremes so duplicates and ties show up.
  function automatic logic [DATA_W-1:0] pick_priority();
    int r;
    r = $urandom_range(99);
    if (r < 25) return $urandom_range(31);
    if (r < 40 && shadow.fill > 0) return shadow.keys[$urandom_range(shadow.fill - 1)];
    if (r < 50) begin
      case ($urandom_range(3))
        0: return '0;
        1: return 32'd1;
        2: return 32'hFFFF_FFFE;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_random(int insert_pct);
    int    r;
    mode_t m;
    r = $urandom_range(99);
    if (r < insert_pct) begin
      m = MODE_INSERT;
    end else begin
      r = $urandom_range(99);
      m = (r < 55) ? MODE_POP : (r < 85) ? MODE_PEEK : MODE_LIST;
    end
    drive_cmd(m, $urandom, pick_priority());
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.owed.size() != 0) @(posedge clk);
  endtask

  initial begin
    shadow          = new();
    hold_req        = 1'b0;
    send_idle_pct   = 27;
    recv_idle_pct   = 68;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_mode         <= MODE_INSERT;
    in_value        <= '0;
    in_priority_req <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty store, extreme keys and values, duplicate, then fill past capacity.
    drive_cmd(MODE_PEEK, '1, '1);
    drive_cmd(MODE_POP, '0, '0);
    drive_cmd(MODE_LIST, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    drive_cmd(MODE_INSERT, '0, '1);
    drive_cmd(MODE_INSERT, '1, '0);
    drive_cmd(MODE_INSERT, 32'h1234_5678, '0);
    drive_cmd(MODE_PEEK, '0, '0);
    drive_cmd(MODE_LIST, '0, '0);
    for (int k = 14; k >= 1; k--)
      drive_cmd(MODE_INSERT, ~(k * 32'h1111_1111), k * 32'h1111_1111);
    drive_cmd(MODE_INSERT, 32'hCAFE_0001, 32'h8000_0000);
    drive_cmd(MODE_INSERT, 32'hCAFE_0002, '0);
    drive_cmd(MODE_LIST, '0, '0);

    repeat (60) send_random(50);
    // Stall results for a long stretch while commands keep coming.
    hold_req = 1'b1;
    repeat (30) send_random(75);
    drain_results();

    send_idle_pct = 68;
    recv_idle_pct = 27;
    repeat (70) send_random(45);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (40) send_random(75);
    repeat (40) send_random(25);

    drain_results();
    repeat (QDEPTH + 8) @(posedge clk);
    if (shadow.owed.size() != 0) begin
      $error("%0d expected results never arrived", shadow.owed.size());
      shadow.errors++;
    end

    $display("covered %0d commands (insert %0d, peek %0d, pop %0d, list %0d), %0d results checked",
             shadow.n_mode[0] + shadow.n_mode[1] + shadow.n_mode[2] + shadow.n_mode[3],
             shadow.n_mode[0], shadow.n_mode[1], shadow.n_mode[2], shadow.n_mode[3],
             shadow.checked);
    $display("outcomes: ok %0d, empty %0d, full %0d, duplicate %0d; deepest fill %0d of %0d",
             shadow.n_status[0], shadow.n_status[1], shadow.n_status[2], shadow.n_status[3],
             shadow.peak_fill, QDEPTH);
    if (shadow.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- min_priority_queue_core.f -----
hw/rtl/mpq_pkg.sv
hw/rtl/mpq_cell.sv
hw/rtl/min_priority_queue_core.sv
hw/rtl/mpq_checker.sv
verif/tb_min_priority_queue_core.sv
